FILE: src/julia_escape_time_pixel_top_defines.svh
// ----------------------------------------------------------------------------
// Julia escape-time pixel: assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define JETP_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define JETP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define JETP_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define JETP_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

FILE: src/jetp_pkg.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: package
// Widths, register indexes, reset values and controller/datapath structs.
// ----------------------------------------------------------------------------
package jetp_pkg;

  localparam int OFF_W     = 10;
  localparam int CFG_W     = 32;
  localparam int VS_W      = 31;
  localparam int Z_W       = 48;
  localparam int R_W       = 32;
  localparam int SQ_W      = 64;
  localparam int NUM_W     = 42;
  localparam int PIX_W     = 10;
  localparam int ITER_O_W  = 7;
  localparam int SHADE_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_C_REAL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_REAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IMAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SIZE   = 3'd4;

  localparam logic [CFG_W-1:0] C_REAL_RST    = 32'hFF4C_CCCD;
  localparam logic [VS_W-1:0]  VIEW_SIZE_RST = 31'h0200_0000;
  localparam logic [R_W-1:0]   R_MIN         = 32'h0400_0000;

  typedef struct packed {
    logic signed [CFG_W-1:0] c_real;
    logic signed [CFG_W-1:0] c_imag;
    logic signed [CFG_W-1:0] center_real;
    logic signed [CFG_W-1:0] center_imag;
    logic [VS_W-1:0]         view_size;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic load_z;
    logic check;
    logic sum;
    logic upd;
    logic res_load;
    logic res_esc;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic far_mag;
    logic far_sum;
    logic iter_last;
  } sts_t;

endpackage

FILE: src/jetp_div.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: constant divider
// Division by a fixed divisor through a reciprocal multiply, one partial
// product per cycle, four partial products in all.
// ----------------------------------------------------------------------------
module jetp_div #(
  parameter int NW      = 42,
  parameter int DW      = 10,
  parameter int DIVISOR = 1000
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  output logic [NW-1:0] quo_o,
  output logic          done_o
);

  localparam int NL  = (NW + 1) / 2;
  localparam int MW  = NW + 2;
  localparam int ML  = (MW + 1) / 2;
  localparam int PPW = NL + ML;
  localparam int SH  = NW + DW;
  localparam int PW  = NW + MW;
  localparam logic [MW-1:0] MULT =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [NW-1:0]  num_q;
  logic [PW-1:0]  acc_q;
  logic [1:0]     step_q;
  logic           busy_q;
  logic [NL-1:0]  op_a;
  logic [ML-1:0]  op_b;
  logic [PPW-1:0] pp;
  logic [PW-1:0]  pp_sh;

  assign op_a   = step_q[0] ? NL'(num_q[NW-1:NL]) : num_q[NL-1:0];
  assign op_b   = step_q[1] ? ML'(MULT[MW-1:ML]) : MULT[ML-1:0];
  assign pp     = PPW'(op_a) * PPW'(op_b);
  assign quo_o  = NW'(acc_q[PW-1:SH]);
  assign done_o = !busy_q;

  always_comb begin
    case (step_q)
      2'd0:    pp_sh = PW'(pp);
      2'd1:    pp_sh = PW'(pp) << NL;
      2'd2:    pp_sh = PW'(pp) << ML;
      default: pp_sh = PW'(pp) << PPW;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

endmodule

FILE: src/jetp_ctrl.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: controller
// Sequences start-point division, escape rounds and the result register.
// ----------------------------------------------------------------------------
module jetp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  jetp_pkg::sts_t sts_i,
  output jetp_pkg::cmd_t cmd_o
);

  import jetp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LOAD,
    S_CHECK,
    S_MULT,
    S_SUM,
    S_UPD,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   esc_q, esc_d;

  always_comb begin
    state_d     = state_q;
    esc_d       = esc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load_z = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.iter_last) begin
          esc_d   = 1'b0;
          state_d = S_DONE;
        end else if (sts_i.far_mag) begin
          esc_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.check = 1'b1;
          state_d     = S_MULT;
        end
      end
      S_MULT: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        if (sts_i.far_sum) begin
          esc_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.sum = 1'b1;
          state_d   = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_CHECK;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_esc  = esc_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      esc_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      esc_q       <= esc_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: src/jetp_datapath.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: datapath
// Start-point mapping, shared complex-square unit, escape tests, result.
// ----------------------------------------------------------------------------
module jetp_datapath #(
  parameter int MAX_ITER      = 100,
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768,
  parameter int SCALE_DIVISOR = 1000
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  jetp_pkg::cfg_t                          cfg_i,
  input  logic signed [jetp_pkg::OFF_W-1:0]       offset_x_i,
  input  logic signed [jetp_pkg::OFF_W-1:0]       offset_y_i,
  input  jetp_pkg::cmd_t                          cmd_i,
  output jetp_pkg::sts_t                          sts_o,
  output logic [jetp_pkg::PIX_W-1:0]              pixel_x_o,
  output logic [jetp_pkg::PIX_W-1:0]              pixel_y_o,
  output logic                                    escaped_o,
  output logic [jetp_pkg::ITER_O_W-1:0]           iter_count_o,
  output logic [jetp_pkg::SHADE_W-1:0]            shade_o
);

  import jetp_pkg::*;

  localparam int             ITW      = $clog2(MAX_ITER + 1);
  localparam int             DIV_W    = $clog2(SCALE_DIVISOR + 1);
  localparam logic [ITW-1:0] ITER_MAX = ITW'(MAX_ITER);
  localparam int             HALF_W   = SCREEN_WIDTH / 2;
  localparam int             HALF_H   = SCREEN_HEIGHT / 2;

  logic signed [OFF_W-1:0] off_x_q, off_y_q;
  logic [OFF_W-1:0]        mag_x, mag_y;
  logic [NUM_W-1:0]        num_x, num_y, quo_x, quo_y;
  logic                    done_x, done_y;
  logic [R_W-1:0]          r_cfg, r_sel, r_q;
  logic [SQ_W-1:0]         r2_q;
  logic signed [Z_W-1:0]   step_x, step_y, z0_r, z0_i;
  logic signed [Z_W-1:0]   zr_q, zi_q;
  logic [Z_W-1:0]          mag_r, mag_i;
  logic [R_W-1:0]          a_q, b_q;
  logic                    neg_q;
  logic [SQ_W-1:0]         a2_q, b2_q, p_q;
  logic [SQ_W:0]           sum;
  logic signed [SQ_W:0]    diff_q, prod_q;
  logic [ITW-1:0]          iter_q;
  logic [31:0]             iter_ext;
  logic [PIX_W-1:0]        pixel_x_q, pixel_y_q;
  logic                    escaped_q;
  logic [ITER_O_W-1:0]     iter_count_q;
  logic [SHADE_W-1:0]      shade_q;

  // start point: center + 2*size*offset/divisor, truncated toward zero
  assign mag_x = offset_x_i[OFF_W-1] ? $unsigned(OFF_W'(-offset_x_i)) : $unsigned(offset_x_i);
  assign mag_y = offset_y_i[OFF_W-1] ? $unsigned(OFF_W'(-offset_y_i)) : $unsigned(offset_y_i);
  assign num_x = NUM_W'({cfg_i.view_size, 1'b0}) * NUM_W'(mag_x);
  assign num_y = NUM_W'({cfg_i.view_size, 1'b0}) * NUM_W'(mag_y);

  jetp_div #(
    .NW      (NUM_W),
    .DW      (DIV_W),
    .DIVISOR (SCALE_DIVISOR)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept),
    .num_i   (num_x),
    .quo_o   (quo_x),
    .done_o  (done_x)
  );

  jetp_div #(
    .NW      (NUM_W),
    .DW      (DIV_W),
    .DIVISOR (SCALE_DIVISOR)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept),
    .num_i   (num_y),
    .quo_o   (quo_y),
    .done_o  (done_y)
  );

  assign step_x = off_x_q[OFF_W-1] ? -$signed(Z_W'(quo_x)) : $signed(Z_W'(quo_x));
  assign step_y = off_y_q[OFF_W-1] ? -$signed(Z_W'(quo_y)) : $signed(Z_W'(quo_y));
  assign z0_r   = Z_W'($signed(cfg_i.center_real)) + step_x;
  assign z0_i   = Z_W'($signed(cfg_i.center_imag)) + step_y;

  assign r_cfg = {cfg_i.view_size, 1'b0};
  assign r_sel = (r_cfg < R_MIN) ? R_MIN : r_cfg;

  assign mag_r = zr_q[Z_W-1] ? $unsigned(Z_W'(-zr_q)) : $unsigned(zr_q);
  assign mag_i = zi_q[Z_W-1] ? $unsigned(Z_W'(-zi_q)) : $unsigned(zi_q);
  assign sum   = {1'b0, a2_q} + {1'b0, b2_q};

  assign sts_o.div_done  = done_x && done_y;
  assign sts_o.far_mag   = (mag_r > Z_W'(r_q)) || (mag_i > Z_W'(r_q));
  assign sts_o.far_sum   = (sum > {1'b0, r2_q});
  assign sts_o.iter_last = (iter_q == ITER_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (cmd_i.accept) begin
      iter_q <= '0;
    end else if (cmd_i.upd) begin
      iter_q <= iter_q + ITW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      off_x_q <= offset_x_i;
      off_y_q <= offset_y_i;
      r_q     <= r_sel;
    end
    if (cmd_i.accept) begin
      a_q <= r_sel;
      b_q <= '0;
    end else if (cmd_i.check) begin
      a_q   <= mag_r[R_W-1:0];
      b_q   <= mag_i[R_W-1:0];
      neg_q <= zr_q[Z_W-1] ^ zi_q[Z_W-1];
    end
    a2_q <= SQ_W'(a_q) * SQ_W'(a_q);
    b2_q <= SQ_W'(b_q) * SQ_W'(b_q);
    p_q  <= SQ_W'(a_q) * SQ_W'(b_q);
    if (cmd_i.load_z) begin
      r2_q <= a2_q;
    end
    if (cmd_i.sum) begin
      diff_q <= $signed({1'b0, a2_q}) - $signed({1'b0, b2_q});
      prod_q <= neg_q ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
    end
    if (cmd_i.load_z) begin
      zr_q <= z0_r;
      zi_q <= z0_i;
    end else if (cmd_i.upd) begin
      zr_q <= Z_W'(diff_q >>> FRAC_W) + Z_W'($signed(cfg_i.c_real));
      zi_q <= Z_W'(prod_q >>> (FRAC_W - 1)) + Z_W'($signed(cfg_i.c_imag));
    end
  end

  assign iter_ext = 32'(iter_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      pixel_x_q    <= $unsigned(off_x_q) + PIX_W'(HALF_W);
      pixel_y_q    <= $unsigned(off_y_q) + PIX_W'(HALF_H);
      escaped_q    <= cmd_i.res_esc;
      iter_count_q <= iter_ext[ITER_O_W-1:0];
      shade_q      <= cmd_i.res_esc ? {iter_ext[SHADE_W-4:0], 3'b000} : '0;
    end
  end

  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign escaped_o    = escaped_q;
  assign iter_count_o = iter_count_q;
  assign shade_o      = shade_q;

endmodule

FILE: src/julia_escape_time_pixel_top.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: top level
// Evaluates the escape time of one screen pixel of a Julia set per
// transaction; holds the view and constant registers.
// ----------------------------------------------------------------------------
// One pixel at a time. After the accepting edge a pixel passes through the
// start-point dividers (four partial products, then a done state), a load
// state, then rounds of the shared complex-square unit (magnitude test,
// multiply, sum and compare, update), a final magnitude test and the result
// register; a round that fails the sum test goes straight to the result. The
// next pixel can be taken the cycle after the result is loaded, while the
// previous result waits in the output register; a result that is not taken
// holds the next one in its last cycle.
// Write the registers only while no pixel is in flight.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_top_defines.svh"

module julia_escape_time_pixel_top #(
  parameter int MAX_ITER      = 100,
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768,
  parameter int SCALE_DIVISOR = 1000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [jetp_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [jetp_pkg::OFF_W-1:0]   offset_x_i,
  input  logic signed [jetp_pkg::OFF_W-1:0]   offset_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [jetp_pkg::PIX_W-1:0]          pixel_x_o,
  output logic [jetp_pkg::PIX_W-1:0]          pixel_y_o,
  output logic                                escaped_o,
  output logic [jetp_pkg::ITER_O_W-1:0]       iter_count_o,
  output logic [jetp_pkg::SHADE_W-1:0]        shade_o
);

  import jetp_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_real      <= C_REAL_RST;
      cfg_q.c_imag      <= '0;
      cfg_q.center_real <= '0;
      cfg_q.center_imag <= '0;
      cfg_q.view_size   <= VIEW_SIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_C_REAL:      cfg_q.c_real      <= cfg_data_i;
        CFG_C_IMAG:      cfg_q.c_imag      <= cfg_data_i;
        CFG_CENTER_REAL: cfg_q.center_real <= cfg_data_i;
        CFG_CENTER_IMAG: cfg_q.center_imag <= cfg_data_i;
        CFG_VIEW_SIZE:   cfg_q.view_size   <= cfg_data_i[VS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  jetp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jetp_datapath #(
    .MAX_ITER      (MAX_ITER),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .SCALE_DIVISOR (SCALE_DIVISOR)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .offset_x_i   (offset_x_i),
    .offset_y_i   (offset_y_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .escaped_o    (escaped_o),
    .iter_count_o (iter_count_o),
    .shade_o      (shade_o)
  );

  `JETP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `JETP_ASSERT_NEXT(a_result_shown, clk_i, rst_ni, cmd.res_load, out_valid_o)
  `JETP_ASSERT_IMPL(a_load_after_divide, clk_i, rst_ni, cmd.load_z, sts.div_done)
  `JETP_ASSERT_IMPL(a_shade_when_bounded, clk_i, rst_ni, out_valid_o && !escaped_o, shade_o == '0)

endmodule
